// File: hw/rtl/ttf_pkg.sv
// shared types and constants for the triangle tangent frame block
package ttf_pkg;

  // datapath operations, one per cycle
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_DELTA,
    OP_FIT_D,
    OP_MUL,
    OP_ACC_SET,
    OP_ACC_ADD,
    OP_ACC_SUB,
    OP_ACC_WSET,
    OP_DET,
    OP_STORE_T,
    OP_STORE_B,
    OP_FIT_TB,
    OP_STORE_D,
    OP_STORE_W,
    OP_NORM,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_STORE,
    OP_EMIT
  } ttf_op_t;

  // multiplier operand pairs
  typedef enum logic [3:0] {
    M_DT03,
    M_DT12,
    M_TA,
    M_TB,
    M_BA,
    M_BB,
    M_ND,
    M_NDH,
    M_NDL,
    M_SQ
  } ttf_msel_t;

  typedef struct packed {
    ttf_op_t   op;
    ttf_msel_t msel;
    logic [1:0] idx;
    logic [1:0] corner;
    logic       vsel;
    logic       deg;
  } ttf_cmd_t;

  typedef struct packed {
    logic fit_d_done;
    logic fit_tb_done;
    logic det_zero;
    logic w_zero;
    logic w_done;
  } ttf_status_t;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 15;
  localparam logic [1:0] LAST_CORNER = 2'd2;
  localparam logic [1:0] LAST_COMP   = 2'd2;
  localparam logic [1:0] LAST_HELD   = 2'd2;

endpackage

// File: hw/rtl/ttf_ctrl.sv
// sequencer for the tangent frame datapath
module ttf_ctrl import ttf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  ttf_status_t st,
  output ttf_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DELTA, S_FIT_D, S_DET, S_TB, S_FIT_TB, S_GS_D, S_GS_W,
    S_NORM, S_SQ, S_SQRT_I, S_SQRT, S_DIV_I, S_DIV, S_DIV_S, S_EMIT
  } state_t;

  state_t     state_r;
  logic [4:0] k_r;
  logic [1:0] j_r;
  logic [1:0] corner_r;
  logic       vsel_r;
  logic       deg_r;
  logic [1:0] vcount_r;
  logic       out_valid_r;
  logic       accept;
  logic       emit_go;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;
  assign emit_go   = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  always_comb begin
    cmd        = '0;
    cmd.op     = OP_NOP;
    cmd.msel   = M_DT03;
    cmd.idx    = j_r;
    cmd.corner = corner_r;
    cmd.vsel   = vsel_r;
    cmd.deg    = deg_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.op  = OP_LOAD;
          cmd.idx = vcount_r;
        end
      end
      S_DELTA: cmd.op = OP_DELTA;
      S_FIT_D: begin
        if (!st.fit_d_done) cmd.op = OP_FIT_D;
      end
      S_DET: begin
        case (k_r)
          5'd0: begin cmd.op = OP_MUL; cmd.msel = M_DT03; end
          5'd1: cmd.op = OP_ACC_SET;
          5'd2: begin cmd.op = OP_MUL; cmd.msel = M_DT12; end
          5'd3: cmd.op = OP_ACC_SUB;
          5'd4: cmd.op = OP_DET;
          default: cmd.op = OP_NOP;
        endcase
      end
      S_TB: begin
        case (k_r)
          5'd0: begin cmd.op = OP_MUL; cmd.msel = M_TA; end
          5'd1: cmd.op = OP_ACC_SET;
          5'd2: begin cmd.op = OP_MUL; cmd.msel = M_TB; end
          5'd3: cmd.op = OP_ACC_SUB;
          5'd4: cmd.op = OP_STORE_T;
          5'd5: begin cmd.op = OP_MUL; cmd.msel = M_BA; end
          5'd6: cmd.op = OP_ACC_SET;
          5'd7: begin cmd.op = OP_MUL; cmd.msel = M_BB; end
          5'd8: cmd.op = OP_ACC_SUB;
          default: cmd.op = OP_STORE_B;
        endcase
      end
      S_FIT_TB: begin
        if (!st.fit_tb_done) cmd.op = OP_FIT_TB;
      end
      S_GS_D: begin
        if (k_r == 5'd6) begin
          cmd.op = OP_STORE_D;
        end else if (!k_r[0]) begin
          cmd.op   = OP_MUL;
          cmd.msel = M_ND;
          cmd.idx  = k_r[2:1];
        end else begin
          cmd.op = (k_r == 5'd1) ? OP_ACC_SET : OP_ACC_ADD;
        end
      end
      S_GS_W: begin
        case (k_r)
          5'd0: begin cmd.op = OP_MUL; cmd.msel = M_NDH; end
          5'd1: cmd.op = OP_ACC_WSET;
          5'd2: begin cmd.op = OP_MUL; cmd.msel = M_NDL; end
          5'd3: cmd.op = OP_ACC_SUB;
          default: cmd.op = OP_STORE_W;
        endcase
      end
      S_NORM: begin
        if (!st.w_zero && !st.w_done) cmd.op = OP_NORM;
      end
      S_SQ: begin
        if (!k_r[0]) begin
          cmd.op   = OP_MUL;
          cmd.msel = M_SQ;
          cmd.idx  = k_r[2:1];
        end else begin
          cmd.op = (k_r == 5'd1) ? OP_ACC_SET : OP_ACC_ADD;
        end
      end
      S_SQRT_I: cmd.op = OP_SQRT_INIT;
      S_SQRT:   cmd.op = OP_SQRT_STEP;
      S_DIV_I:  cmd.op = OP_DIV_INIT;
      S_DIV:    cmd.op = OP_DIV_STEP;
      S_DIV_S:  cmd.op = OP_DIV_STORE;
      S_EMIT: begin
        if (emit_go) cmd.op = OP_EMIT;
      end
      default: cmd.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      j_r         <= '0;
      corner_r    <= '0;
      vsel_r      <= 1'b0;
      deg_r       <= 1'b0;
      vcount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit_go) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (vcount_r == LAST_HELD) begin
              vcount_r <= '0;
              state_r  <= S_DELTA;
            end else begin
              vcount_r <= vcount_r + 2'd1;
            end
          end
        end
        S_DELTA: state_r <= S_FIT_D;
        S_FIT_D: begin
          if (st.fit_d_done) begin
            k_r     <= '0;
            state_r <= S_DET;
          end
        end
        S_DET: begin
          if (k_r == 5'd5) begin
            k_r      <= '0;
            j_r      <= '0;
            corner_r <= '0;
            vsel_r   <= 1'b0;
            if (st.det_zero) begin
              deg_r   <= 1'b1;
              state_r <= S_EMIT;
            end else begin
              deg_r   <= 1'b0;
              state_r <= S_TB;
            end
          end else begin
            k_r <= k_r + 5'd1;
          end
        end
        S_TB: begin
          if (k_r == 5'd9) begin
            k_r <= '0;
            if (j_r == LAST_COMP) begin
              j_r     <= '0;
              state_r <= S_FIT_TB;
            end else begin
              j_r <= j_r + 2'd1;
            end
          end else begin
            k_r <= k_r + 5'd1;
          end
        end
        S_FIT_TB: begin
          if (st.fit_tb_done) begin
            k_r     <= '0;
            state_r <= S_GS_D;
          end
        end
        S_GS_D: begin
          if (k_r == 5'd6) begin
            k_r     <= '0;
            j_r     <= '0;
            state_r <= S_GS_W;
          end else begin
            k_r <= k_r + 5'd1;
          end
        end
        S_GS_W: begin
          if (k_r == 5'd4) begin
            k_r <= '0;
            if (j_r == LAST_COMP) begin
              j_r     <= '0;
              state_r <= S_NORM;
            end else begin
              j_r <= j_r + 2'd1;
            end
          end else begin
            k_r <= k_r + 5'd1;
          end
        end
        S_NORM: begin
          if (st.w_zero) begin
            deg_r   <= 1'b1;
            state_r <= S_EMIT;
          end else if (st.w_done) begin
            k_r     <= '0;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          if (k_r == 5'd5) begin
            k_r     <= '0;
            state_r <= S_SQRT_I;
          end else begin
            k_r <= k_r + 5'd1;
          end
        end
        S_SQRT_I: begin
          k_r     <= '0;
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          if (k_r == 5'(SQRT_STEPS - 1)) begin
            k_r     <= '0;
            j_r     <= '0;
            state_r <= S_DIV_I;
          end else begin
            k_r <= k_r + 5'd1;
          end
        end
        S_DIV_I: begin
          k_r     <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (k_r == 5'(DIV_STEPS - 1)) begin
            state_r <= S_DIV_S;
          end else begin
            k_r <= k_r + 5'd1;
          end
        end
        S_DIV_S: begin
          if (j_r == LAST_COMP) begin
            j_r <= '0;
            k_r <= '0;
            if (!vsel_r) begin
              vsel_r  <= 1'b1;
              state_r <= S_GS_D;
            end else begin
              state_r <= S_EMIT;
            end
          end else begin
            j_r     <= j_r + 2'd1;
            state_r <= S_DIV_I;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            k_r    <= '0;
            j_r    <= '0;
            vsel_r <= 1'b0;
            if (corner_r == LAST_CORNER) begin
              corner_r <= '0;
              deg_r    <= 1'b0;
              state_r  <= S_IDLE;
            end else begin
              corner_r <= corner_r + 2'd1;
              if (!st.det_zero) begin
                deg_r   <= 1'b0;
                state_r <= S_GS_D;
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/ttf_datapath.sv
// vertex store, shared multiplier, square root and divider of the tangent frame
module ttf_datapath import ttf_pkg::*; (
  input  logic               clk,
  input  ttf_cmd_t           cmd,
  output ttf_status_t        st,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_tex_u,
  input  logic signed [31:0] in_tex_v,
  input  logic signed [15:0] in_norm_x,
  input  logic signed [15:0] in_norm_y,
  input  logic signed [15:0] in_norm_z,
  output logic signed [15:0] out_tangent_x,
  output logic signed [15:0] out_tangent_y,
  output logic signed [15:0] out_tangent_z,
  output logic signed [15:0] out_bitan_x,
  output logic signed [15:0] out_bitan_y,
  output logic signed [15:0] out_bitan_z,
  output logic [1:0]         out_corner,
  output logic               out_degenerate,
  output logic               out_last
);

  logic signed [31:0] pos_r [3][3];
  logic signed [31:0] tex_r [3][2];
  logic signed [15:0] nrm_r [3][3];
  logic signed [32:0] dp_r [6];
  logic signed [32:0] dt_r [4];
  logic signed [63:0] prod_r;
  logic signed [63:0] acc_r;
  logic               det_neg_r;
  logic               det_zero_r;
  logic signed [63:0] tv_r [3];
  logic signed [63:0] bv_r [3];
  logic signed [47:0] d_r;
  logic signed [63:0] w_r [3];
  logic [63:0]        sq_rem_r;
  logic [63:0]        sq_res_r;
  logic [63:0]        sq_bit_r;
  logic [45:0]        dv_rem_r;
  logic [45:0]        dv_div_r;
  logic [14:0]        q_r;
  logic               q_neg_r;
  logic signed [15:0] ut_r [3];
  logic signed [15:0] ub_r [3];
  logic signed [15:0] o_t_r [3];
  logic signed [15:0] o_b_r [3];
  logic [1:0]         o_corner_r;
  logic               o_deg_r;
  logic               o_last_r;

  logic [2:0]         dp_idx;
  logic signed [32:0] dp_sel;
  logic signed [63:0] vec_sel;
  logic signed [15:0] n_sel;
  logic signed [63:0] w_sel;
  logic signed [32:0] opa;
  logic signed [32:0] opb;
  logic signed [65:0] mul_full;
  logic               dp_fit, dt_fit, tv_fit, bv_fit, w_fit, w_small, w_zero;
  logic [63:0]        sq_try;
  logic signed [63:0] w_neg;
  logic [30:0]        w_abs;
  logic signed [15:0] q_ext;

  function automatic logic fit33(input logic [32:0] x);
    fit33 = (x[32:30] == 3'b000) || (x[32:30] == 3'b111);
  endfunction

  function automatic logic fit28(input logic [63:0] x);
    fit28 = (&x[63:28]) || !(|x[63:28]);
  endfunction

  function automatic logic fit30(input logic [63:0] x);
    fit30 = (&x[63:30]) || !(|x[63:30]);
  endfunction

  // strictly inside (-2^29, 2^29)
  function automatic logic in29(input logic [63:0] x);
    in29 = ((&x[63:29]) && (|x[28:0])) || !(|x[63:29]);
  endfunction

  assign dp_idx  = (cmd.msel == M_TA || cmd.msel == M_BB) ? {1'b0, cmd.idx}
                                                          : {1'b0, cmd.idx} + 3'd3;
  assign dp_sel  = dp_r[dp_idx];
  assign vec_sel = cmd.vsel ? bv_r[cmd.idx] : tv_r[cmd.idx];
  assign n_sel   = nrm_r[cmd.corner][cmd.idx];
  assign w_sel   = w_r[cmd.idx];

  always_comb begin
    case (cmd.msel)
      M_DT03: begin opa = dt_r[0]; opb = dt_r[3]; end
      M_DT12: begin opa = dt_r[1]; opb = dt_r[2]; end
      M_TA:   begin opa = dp_sel;  opb = dt_r[3]; end
      M_TB:   begin opa = dp_sel;  opb = dt_r[1]; end
      M_BA:   begin opa = dp_sel;  opb = dt_r[0]; end
      M_BB:   begin opa = dp_sel;  opb = dt_r[2]; end
      M_ND:   begin opa = 33'(n_sel); opb = $signed(vec_sel[32:0]); end
      M_NDH:  begin opa = 33'(n_sel); opb = 33'($signed(d_r[47:24])); end
      M_NDL:  begin opa = 33'(n_sel); opb = $signed({9'd0, d_r[23:0]}); end
      M_SQ:   begin opa = $signed(w_sel[32:0]); opb = $signed(w_sel[32:0]); end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  assign mul_full = opa * opb;

  always_comb begin
    dp_fit = 1'b1;
    dt_fit = 1'b1;
    tv_fit = 1'b1;
    bv_fit = 1'b1;
    w_fit  = 1'b1;
    w_small = 1'b1;
    w_zero = 1'b1;
    for (int i = 0; i < 6; i++) if (!fit33(dp_r[i])) dp_fit = 1'b0;
    for (int i = 0; i < 4; i++) if (!fit33(dt_r[i])) dt_fit = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (!fit28(tv_r[i])) tv_fit = 1'b0;
      if (!fit28(bv_r[i])) bv_fit = 1'b0;
      if (!fit30(w_r[i])) w_fit = 1'b0;
      if (!in29(w_r[i])) w_small = 1'b0;
      if (w_r[i] != 64'sd0) w_zero = 1'b0;
    end
  end

  assign st.fit_d_done  = dp_fit && dt_fit;
  assign st.fit_tb_done = tv_fit && bv_fit;
  assign st.det_zero    = det_zero_r;
  assign st.w_zero      = w_zero;
  assign st.w_done      = w_fit && !w_small;

  assign sq_try = sq_res_r + sq_bit_r;
  assign w_neg  = -w_sel;
  assign w_abs  = w_sel[63] ? w_neg[30:0] : w_sel[30:0];
  assign q_ext  = $signed({1'b0, q_r});

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        pos_r[cmd.idx][0] <= in_pos_x;
        pos_r[cmd.idx][1] <= in_pos_y;
        pos_r[cmd.idx][2] <= in_pos_z;
        tex_r[cmd.idx][0] <= in_tex_u;
        tex_r[cmd.idx][1] <= in_tex_v;
        nrm_r[cmd.idx][0] <= in_norm_x;
        nrm_r[cmd.idx][1] <= in_norm_y;
        nrm_r[cmd.idx][2] <= in_norm_z;
      end
      OP_DELTA: begin
        for (int i = 0; i < 3; i++) begin
          dp_r[i]     <= 33'(pos_r[1][i]) - 33'(pos_r[0][i]);
          dp_r[3 + i] <= 33'(pos_r[2][i]) - 33'(pos_r[0][i]);
        end
        dt_r[0] <= 33'(tex_r[1][0]) - 33'(tex_r[0][0]);
        dt_r[1] <= 33'(tex_r[1][1]) - 33'(tex_r[0][1]);
        dt_r[2] <= 33'(tex_r[2][0]) - 33'(tex_r[0][0]);
        dt_r[3] <= 33'(tex_r[2][1]) - 33'(tex_r[0][1]);
      end
      OP_FIT_D: begin
        if (!dp_fit) for (int i = 0; i < 6; i++) dp_r[i] <= dp_r[i] >>> 1;
        if (!dt_fit) for (int i = 0; i < 4; i++) dt_r[i] <= dt_r[i] >>> 1;
      end
      OP_MUL:      prod_r <= mul_full[63:0];
      OP_ACC_SET:  acc_r <= prod_r;
      OP_ACC_ADD:  acc_r <= acc_r + prod_r;
      OP_ACC_SUB:  acc_r <= acc_r - prod_r;
      OP_ACC_WSET: acc_r <= (vec_sel <<< 28) - (prod_r <<< 24);
      OP_DET: begin
        det_neg_r  <= acc_r[63];
        det_zero_r <= (acc_r == 64'sd0);
      end
      OP_STORE_T: tv_r[cmd.idx] <= det_neg_r ? -acc_r : acc_r;
      OP_STORE_B: bv_r[cmd.idx] <= det_neg_r ? -acc_r : acc_r;
      OP_FIT_TB: begin
        if (!tv_fit) for (int i = 0; i < 3; i++) tv_r[i] <= tv_r[i] >>> 1;
        if (!bv_fit) for (int i = 0; i < 3; i++) bv_r[i] <= bv_r[i] >>> 1;
      end
      OP_STORE_D: d_r <= acc_r[47:0];
      OP_STORE_W: w_r[cmd.idx] <= acc_r;
      OP_NORM: begin
        // fit down first, then scale up until the top bit reaches 2^29
        for (int i = 0; i < 3; i++) w_r[i] <= w_fit ? (w_r[i] <<< 1) : (w_r[i] >>> 1);
      end
      OP_SQRT_INIT: begin
        sq_rem_r <= acc_r;
        sq_res_r <= '0;
        sq_bit_r <= 64'd1 << 62;
      end
      OP_SQRT_STEP: begin
        if (sq_rem_r >= sq_try) begin
          sq_rem_r <= sq_rem_r - sq_try;
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
      end
      OP_DIV_INIT: begin
        // numerator carries half the divisor for round half away from zero
        dv_rem_r <= 46'({w_abs, 14'd0}) + 46'(sq_res_r[31:1]);
        dv_div_r <= {sq_res_r[31:0], 14'd0};
        q_r      <= '0;
        q_neg_r  <= w_sel[63];
      end
      OP_DIV_STEP: begin
        if (dv_rem_r >= dv_div_r) begin
          dv_rem_r <= dv_rem_r - dv_div_r;
          q_r      <= {q_r[13:0], 1'b1};
        end else begin
          q_r <= {q_r[13:0], 1'b0};
        end
        dv_div_r <= dv_div_r >> 1;
      end
      OP_DIV_STORE: begin
        if (cmd.vsel) ub_r[cmd.idx] <= q_neg_r ? -q_ext : q_ext;
        else          ut_r[cmd.idx] <= q_neg_r ? -q_ext : q_ext;
      end
      OP_EMIT: begin
        for (int i = 0; i < 3; i++) begin
          o_t_r[i] <= cmd.deg ? 16'sd0 : ut_r[i];
          o_b_r[i] <= cmd.deg ? 16'sd0 : ub_r[i];
        end
        o_corner_r <= cmd.corner;
        o_deg_r    <= cmd.deg;
        o_last_r   <= (cmd.corner == LAST_CORNER);
      end
      default: ;
    endcase
  end

  assign out_tangent_x  = o_t_r[0];
  assign out_tangent_y  = o_t_r[1];
  assign out_tangent_z  = o_t_r[2];
  assign out_bitan_x    = o_b_r[0];
  assign out_bitan_y    = o_b_r[1];
  assign out_bitan_z    = o_b_r[2];
  assign out_corner     = o_corner_r;
  assign out_degenerate = o_deg_r;
  assign out_last       = o_last_r;

endmodule

// File: hw/rtl/triangle_tangent_frame.sv
// per-triangle tangent and bitangent with gram-schmidt, top level
// vertices 0 and 1 of a group are only stored; the third starts the triangle
// triangle: deltas, determinant and tangent build, then per corner two vectors, each
// orthogonalized to the normal, shifted into range, then a 32-step square root and
// three bit-serial divides; one shared multiplier serves every product; a zero
// determinant sends all three corners straight out as degenerate frames
// synchronous active-low reset empties the vertex group and clears the result valid flag
module triangle_tangent_frame import ttf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_tex_u,
  input  logic signed [31:0] in_tex_v,
  input  logic signed [15:0] in_norm_x,
  input  logic signed [15:0] in_norm_y,
  input  logic signed [15:0] in_norm_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_tangent_x,
  output logic signed [15:0] out_tangent_y,
  output logic signed [15:0] out_tangent_z,
  output logic signed [15:0] out_bitan_x,
  output logic signed [15:0] out_bitan_y,
  output logic signed [15:0] out_bitan_z,
  output logic [1:0]         out_corner,
  output logic               out_degenerate,
  output logic               out_last
);

  // command and status between sequencer and datapath
  ttf_cmd_t    cmd;
  ttf_status_t st;

  // sequencer: vertex count, triangle phases, result transfer
  ttf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // datapath: vertex store, multiplier, root and divider, result register
  ttf_datapath u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .st             (st),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .in_tex_u       (in_tex_u),
    .in_tex_v       (in_tex_v),
    .in_norm_x      (in_norm_x),
    .in_norm_y      (in_norm_y),
    .in_norm_z      (in_norm_z),
    .out_tangent_x  (out_tangent_x),
    .out_tangent_y  (out_tangent_y),
    .out_tangent_z  (out_tangent_z),
    .out_bitan_x    (out_bitan_x),
    .out_bitan_y    (out_bitan_y),
    .out_bitan_z    (out_bitan_z),
    .out_corner     (out_corner),
    .out_degenerate (out_degenerate),
    .out_last       (out_last)
  );

endmodule

// File: tb/triangle_tangent_frame_tb.sv
// testbench for the triangle tangent frame block: directed table, random triangles, predictor
`timescale 1ns / 100ps

module triangle_tangent_frame_tb import ttf_pkg::*;;

  localparam int          TOTAL_ITEMS = 230;
  localparam int          IDLE_LIMIT  = 6000;  // cycles with no transfer before giving up
  localparam longint      LIM30 = 64'sd1 <<< 30;
  localparam longint      LIM29 = 64'sd1 <<< 29;
  localparam longint      LIM28 = 64'sd1 <<< 28;
  localparam logic [15:0] ONE_Q14 = 16'sd16384;

  typedef struct {
    logic signed [31:0] px, py, pz, tu, tv;
    logic signed [15:0] nx, ny, nz;
  } vertex_t;

  typedef struct {
    logic signed [15:0] tx, ty, tz, bx, by, bz;
    logic [1:0]         corner;
    logic               degenerate;
    logic               last;
  } frame_t;

  // how the third row of a directed triangle is checked
  typedef enum int {EXP_MODEL, EXP_DEGEN, EXP_UNIT_XY} exp_kind_t;

  typedef struct {
    vertex_t   v;
    exp_kind_t kind;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [31:0] in_tex_u = '0, in_tex_v = '0;
  logic signed [15:0] in_norm_x = '0, in_norm_y = '0, in_norm_z = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_tangent_x, out_tangent_y, out_tangent_z;
  logic signed [15:0] out_bitan_x, out_bitan_y, out_bitan_z;
  logic [1:0]         out_corner;
  logic               out_degenerate;
  logic               out_last;

  triangle_tangent_frame dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // predictor state: vertices of the open group
  vertex_t   held_vtx[2];
  int        held_count = 0;
  frame_t    frames_due[$];
  stim_row_t stim_table[$];

  int errors = 0;
  int items_sent = 0;
  int frames_seen = 0;
  int degen_seen = 0;
  int idle_cycles = 0;

  // shift the whole group right until every entry fits [-lim, lim-1]
  function automatic void fit_group(inout longint v[6], input int n, input longint lim);
    bit fits;
    forever begin
      fits = 1'b1;
      for (int i = 0; i < n; i++) if (v[i] < -lim || v[i] > lim - 1) fits = 1'b0;
      if (fits) return;
      for (int i = 0; i < n; i++) v[i] = v[i] >>> 1;
    end
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned s);
    longint unsigned root = 0;
    longint unsigned probe = 64'd1 << 62;
    while (probe > s) probe = probe >> 2;
    while (probe != 0) begin
      if (s >= root + probe) begin
        s = s - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // scale to q2.14 unit length; 0 when the vector is zero
  function automatic bit to_unit(input longint w_in[6], output logic signed [15:0] u[3]);
    longint          w[6];
    longint unsigned sum_sq = 0;
    longint unsigned root, mag;
    longint          q;
    w = w_in;
    fit_group(w, 3, LIM30);
    if (w[0] == 0 && w[1] == 0 && w[2] == 0) return 1'b0;
    while (w[0] > -LIM29 && w[0] < LIM29 && w[1] > -LIM29 && w[1] < LIM29 &&
           w[2] > -LIM29 && w[2] < LIM29)
      for (int i = 0; i < 3; i++) w[i] = w[i] * 2;
    for (int i = 0; i < 3; i++) sum_sq += longint'(w[i] * w[i]);
    root = int_sqrt(sum_sq);
    if (root == 0) return 1'b0;
    for (int i = 0; i < 3; i++) begin
      mag = (w[i] < 0 ? -w[i] : w[i]) * 64'd16384;
      q = longint'((mag + root / 2) / root);
      if (w[i] < 0) q = -q;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      u[i] = q[15:0];
    end
    return 1'b1;
  endfunction

  // remove the normal component: w = t*2^28 - n*(n.t)
  function automatic void strip_normal(input longint t[6], input vertex_t nv,
                                       output longint w[6]);
    longint nrm[3];
    longint dotp;
    nrm[0] = nv.nx; nrm[1] = nv.ny; nrm[2] = nv.nz;
    dotp = nrm[0] * t[0] + nrm[1] * t[1] + nrm[2] * t[2];
    w = '{0, 0, 0, 0, 0, 0};
    for (int i = 0; i < 3; i++) w[i] = t[i] * LIM28 - nrm[i] * dotp;
  endfunction

  // third vertex closes the triangle and queues its three corner frames
  function automatic void predict_frames(input vertex_t v2);
    vertex_t corner_vtx[3];
    longint  dp[6], dt[6], tan_v[6], bit_v[6], wt[6], wb[6];
    longint  det;
    logic signed [15:0] ut[3], ub[3];
    frame_t  f;
    bit      deg;
    corner_vtx[0] = held_vtx[0];
    corner_vtx[1] = held_vtx[1];
    corner_vtx[2] = v2;
    dp[0] = longint'(corner_vtx[1].px) - corner_vtx[0].px;
    dp[1] = longint'(corner_vtx[1].py) - corner_vtx[0].py;
    dp[2] = longint'(corner_vtx[1].pz) - corner_vtx[0].pz;
    dp[3] = longint'(corner_vtx[2].px) - corner_vtx[0].px;
    dp[4] = longint'(corner_vtx[2].py) - corner_vtx[0].py;
    dp[5] = longint'(corner_vtx[2].pz) - corner_vtx[0].pz;
    dt = '{0, 0, 0, 0, 0, 0};
    dt[0] = longint'(corner_vtx[1].tu) - corner_vtx[0].tu;
    dt[1] = longint'(corner_vtx[1].tv) - corner_vtx[0].tv;
    dt[2] = longint'(corner_vtx[2].tu) - corner_vtx[0].tu;
    dt[3] = longint'(corner_vtx[2].tv) - corner_vtx[0].tv;
    fit_group(dp, 6, LIM30);
    fit_group(dt, 4, LIM30);
    det = dt[0] * dt[3] - dt[1] * dt[2];
    tan_v = '{0, 0, 0, 0, 0, 0};
    bit_v = '{0, 0, 0, 0, 0, 0};
    for (int i = 0; i < 3; i++) begin
      tan_v[i] = dp[i] * dt[3] - dp[3 + i] * dt[1];
      bit_v[i] = dp[3 + i] * dt[0] - dp[i] * dt[2];
      if (det < 0) begin
        tan_v[i] = -tan_v[i];
        bit_v[i] = -bit_v[i];
      end
    end
    fit_group(tan_v, 3, LIM28);
    fit_group(bit_v, 3, LIM28);
    for (int c = 0; c < 3; c++) begin
      deg = (det == 0);
      ut = '{0, 0, 0};
      ub = '{0, 0, 0};
      if (!deg) begin
        strip_normal(tan_v, corner_vtx[c], wt);
        strip_normal(bit_v, corner_vtx[c], wb);
        if (!to_unit(wt, ut) || !to_unit(wb, ub)) deg = 1'b1;
      end
      if (deg) begin
        ut = '{0, 0, 0};
        ub = '{0, 0, 0};
      end
      f.tx = ut[0]; f.ty = ut[1]; f.tz = ut[2];
      f.bx = ub[0]; f.by = ub[1]; f.bz = ub[2];
      f.corner = c[1:0];
      f.degenerate = deg;
      f.last = (c[1:0] == LAST_CORNER);
      frames_due = {frames_due, f};
    end
  endfunction

  // predictor entry point for every accepted vertex
  function automatic void accept_vertex(input vertex_t v, input exp_kind_t kind);
    frame_t f;
    if (held_count < 2) begin
      held_vtx[held_count] = v;
      held_count++;
      return;
    end
    held_count = 0;
    if (kind == EXP_MODEL) begin
      predict_frames(v);
      return;
    end
    // typed-in expectations: zeroed frames, or the plain x/y unit frame
    for (int c = 0; c < 3; c++) begin
      f = '{default: '0};
      f.corner = c[1:0];
      f.last = (c[1:0] == LAST_CORNER);
      if (kind == EXP_DEGEN) begin
        f.degenerate = 1'b1;
      end else begin
        f.tx = ONE_Q14;
        f.by = ONE_Q14;
      end
      frames_due = {frames_due, f};
    end
  endfunction

  function automatic vertex_t mk_vtx(longint px, longint py, longint pz, longint tu,
                                     longint tv, longint nx, longint ny, longint nz);
    vertex_t v;
    v.px = 32'(px); v.py = 32'(py); v.pz = 32'(pz); v.tu = 32'(tu); v.tv = 32'(tv);
    v.nx = 16'(nx); v.ny = 16'(ny); v.nz = 16'(nz);
    return v;
  endfunction

  function automatic void add_row(vertex_t v, exp_kind_t kind);
    stim_row_t r;
    r.v = v;
    r.kind = kind;
    stim_table = {stim_table, r};
  endfunction

  function automatic logic signed [31:0] rnd_span(int unsigned half);
    return $signed($urandom_range(0, 2 * half)) - $signed(half);
  endfunction

  function automatic vertex_t rnd_vertex(int mode);
    vertex_t v;
    if (mode == 0) begin
      // full 32/16-bit patterns
      v = mk_vtx($signed($urandom), $signed($urandom), $signed($urandom),
                 $signed($urandom), $signed($urandom),
                 $signed($urandom_range(0, 65535)), $signed($urandom_range(0, 65535)),
                 $signed($urandom_range(0, 65535)));
      v.nx = 16'($urandom); v.ny = 16'($urandom); v.nz = 16'($urandom);
    end else begin
      // mesh-sized geometry with sensible normals
      v.px = rnd_span(1 << 22); v.py = rnd_span(1 << 22); v.pz = rnd_span(1 << 22);
      v.tu = rnd_span(1 << 17); v.tv = rnd_span(1 << 17);
      v.nx = 16'(rnd_span(16384)); v.ny = 16'(rnd_span(16384));
      v.nz = 16'(rnd_span(16384));
    end
    return v;
  endfunction

  // one vertex transfer; in_valid stays high for the caller to lower or reuse, unless a random gap follows
  task automatic send_vertex(vertex_t v, exp_kind_t kind);
    int gap;
    in_valid  <= 1'b1;
    in_pos_x  <= v.px; in_pos_y <= v.py; in_pos_z <= v.pz;
    in_tex_u  <= v.tu; in_tex_v <= v.tv;
    in_norm_x <= v.nx; in_norm_y <= v.ny; in_norm_z <= v.nz;
    do @(posedge clk); while (!in_ready);
    accept_vertex(v, kind);
    items_sent++;
    // mostly back to back, sometimes a short gap, rarely a long one
    gap = $urandom_range(0, 99);
    gap = (gap < 60) ? 0 : (gap < 94) ? $urandom_range(1, 4) : $urandom_range(20, 70);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // result side: random back-pressure and the field-by-field check
  int stall_left = 0;
  always @(posedge clk) begin
    frame_t f;
    int     pick;
    if (rst_n && out_valid && out_ready) begin
      frames_seen++;
      if (frames_due.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        f = frames_due.pop_front();
        if (f.degenerate) degen_seen++;
        if (out_tangent_x !== f.tx) begin
          $error("tangent_x expected %0d got %0d", f.tx, out_tangent_x); errors++;
        end
        if (out_tangent_y !== f.ty) begin
          $error("tangent_y expected %0d got %0d", f.ty, out_tangent_y); errors++;
        end
        if (out_tangent_z !== f.tz) begin
          $error("tangent_z expected %0d got %0d", f.tz, out_tangent_z); errors++;
        end
        if (out_bitan_x !== f.bx) begin
          $error("bitan_x expected %0d got %0d", f.bx, out_bitan_x); errors++;
        end
        if (out_bitan_y !== f.by) begin
          $error("bitan_y expected %0d got %0d", f.by, out_bitan_y); errors++;
        end
        if (out_bitan_z !== f.bz) begin
          $error("bitan_z expected %0d got %0d", f.bz, out_bitan_z); errors++;
        end
        if (out_corner !== f.corner) begin
          $error("corner expected %0d got %0d", f.corner, out_corner); errors++;
        end
        if (out_degenerate !== f.degenerate) begin
          $error("degenerate expected %0d got %0d", f.degenerate, out_degenerate); errors++;
        end
        if (out_last !== f.last) begin
          $error("last expected %0d got %0d", f.last, out_last); errors++;
        end
      end
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 3) stall_left <= $urandom_range(30, 90);
      else if (pick < 20) stall_left <= $urandom_range(1, 4);
    end
  end

  // watchdog: too long without any transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int kind;
    vertex_t v0, v1, v2;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // right triangle in the xy plane, normal +z: tangent +x, bitangent +y
    add_row(mk_vtx(0, 0, 0, 0, 0, 0, 0, 16384), EXP_MODEL);
    add_row(mk_vtx(1 << 16, 0, 0, 1 << 16, 0, 0, 0, 16384), EXP_MODEL);
    add_row(mk_vtx(0, 1 << 16, 0, 0, 1 << 16, 0, 0, 16384), EXP_UNIT_XY);
    // zero determinant: all texture coordinates equal
    add_row(mk_vtx(5, 7, 9, 123, 456, 0, 0, 16384), EXP_MODEL);
    add_row(mk_vtx(1 << 20, 3, -9, 123, 456, 16384, 0, 0), EXP_MODEL);
    add_row(mk_vtx(-4, 1 << 19, 2, 123, 456, 0, 16384, 0), EXP_DEGEN);
    // tangent along the normal at every corner: vector vanishes
    add_row(mk_vtx(0, 0, 0, 0, 0, 16384, 0, 0), EXP_MODEL);
    add_row(mk_vtx(1 << 16, 0, 0, 1 << 16, 0, 16384, 0, 0), EXP_MODEL);
    add_row(mk_vtx(1 << 17, 0, 0, 0, 1 << 16, 16384, 0, 0), EXP_DEGEN);
    // position and texture extremes, extreme normals
    add_row(mk_vtx(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                   32'sh8000_0000, 32'sh7fff_ffff, -32768, 32767, -32768), EXP_MODEL);
    add_row(mk_vtx(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                   32'sh7fff_ffff, 32'sh8000_0000, 32767, -32768, 32767), EXP_MODEL);
    add_row(mk_vtx(0, 0, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000,
                   32767, 32767, 32767), EXP_MODEL);
    // zero normals: vectors pass through unchanged
    add_row(mk_vtx(0, 0, 0, 0, 0, 0, 0, 0), EXP_MODEL);
    add_row(mk_vtx(3 << 16, 1 << 16, 0, 1 << 15, 1 << 10, 0, 0, 0), EXP_MODEL);
    add_row(mk_vtx(-1 << 16, 2 << 16, 5, -1 << 12, 1 << 15, 0, 0, 0), EXP_MODEL);
    // negative determinant, mirrored texture
    add_row(mk_vtx(0, 0, 0, 0, 0, 0, 0, 16384), EXP_MODEL);
    add_row(mk_vtx(1 << 16, 0, 0, -1 << 16, 0, 0, 0, 16384), EXP_MODEL);
    add_row(mk_vtx(0, 1 << 16, 0, 0, 1 << 16, 100, -200, 16000), EXP_MODEL);

    foreach (stim_table[i]) send_vertex(stim_table[i].v, stim_table[i].kind);

    while (items_sent < TOTAL_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 5) begin
        // stray vertex, shifts the grouping
        send_vertex(rnd_vertex($urandom_range(0, 1)), EXP_MODEL);
      end else begin
        v0 = rnd_vertex(kind < 30 ? 0 : 1);
        v1 = rnd_vertex(kind < 30 ? 0 : 1);
        v2 = rnd_vertex(kind < 30 ? 0 : 1);
        if (kind >= 90) begin
          // collinear texture coordinates give a zero determinant
          v1.tu = v0.tu + 32'sd2 * (v2.tu - v0.tu);
          v1.tv = v0.tv + 32'sd2 * (v2.tv - v0.tv);
        end
        send_vertex(v0, EXP_MODEL);
        send_vertex(v1, EXP_MODEL);
        send_vertex(v2, EXP_MODEL);
      end
    end
    in_valid <= 1'b0;

    while (frames_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("vertices sent: %0d, frames checked: %0d (%0d degenerate)",
             items_sent, frames_seen, degen_seen);
    if (errors == 0 && frames_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/ttf_pkg.sv
hw/rtl/ttf_ctrl.sv
hw/rtl/ttf_datapath.sv
hw/rtl/triangle_tangent_frame.sv
tb/triangle_tangent_frame_tb.sv
